[src/dcci_pkg.sv]
`default_nettype none

package dcci_pkg;

  // Command codes carried with each request.
  localparam logic CMD_INTERPOLATE = 1'b0;
  localparam logic CMD_DEPTH_CUE   = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_BLUE  = 2'd2;

  // Fixed field widths.
  localparam int unsigned CHAN_W  = 16;
  localparam int unsigned FAR_W   = 32;
  localparam int unsigned MAC_W   = 32;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned BYTE_W  = 8;

  // Register enables for the three pipeline stages.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } stage_en_t;

endpackage

`default_nettype wire

[src/dcci_lane.sv]
`default_nettype none

// One colour channel: difference and saturation, multiply, then sum, shift and clamp.
module dcci_lane (
  input  wire logic                                    clk_i,
  input  wire dcci_pkg::stage_en_t                     en_i,
  input  wire logic signed [dcci_pkg::CHAN_W-1:0]      src_i,
  input  wire logic signed [dcci_pkg::FAR_W-1:0]       far_i,
  input  wire logic signed [dcci_pkg::CHAN_W-1:0]      blend_i,
  output logic signed [dcci_pkg::MAC_W-1:0]            mac_o,
  output logic        [dcci_pkg::BYTE_W-1:0]           byte_o
);

  logic signed [dcci_pkg::FAR_W-1:0]  diff;
  logic signed [dcci_pkg::CHAN_W-1:0] sat_d;
  logic signed [dcci_pkg::CHAN_W-1:0] src1_q, sat1_q, w1_q;
  logic signed [dcci_pkg::CHAN_W-1:0] src2_q;
  logic signed [dcci_pkg::PROD_W-1:0] prod_d, prod2_q;
  logic signed [dcci_pkg::SUM_W-1:0]  sum;
  logic signed [dcci_pkg::MAC_W-1:0]  mac_d, mac3_q;
  logic        [dcci_pkg::BYTE_W-1:0] byte_d, byte3_q;

  // The 44-bit wrap followed by the shift by twelve leaves the difference
  // wrapped to 32 bits.
  assign diff = far_i - dcci_pkg::FAR_W'(src_i);

  always_comb begin
    if (diff[dcci_pkg::FAR_W-1] && !(&diff[dcci_pkg::FAR_W-2:dcci_pkg::CHAN_W-1])) begin
      sat_d = {1'b1, {(dcci_pkg::CHAN_W-1){1'b0}}};
    end else if (!diff[dcci_pkg::FAR_W-1] && (|diff[dcci_pkg::FAR_W-2:dcci_pkg::CHAN_W-1])) begin
      sat_d = {1'b0, {(dcci_pkg::CHAN_W-1){1'b1}}};
    end else begin
      sat_d = diff[dcci_pkg::CHAN_W-1:0];
    end
  end

  assign prod_d = sat1_q * w1_q;

  // The sum never exceeds 34 bits, so the 44-bit wrap has no effect here.
  assign sum = (dcci_pkg::SUM_W'(src2_q) <<< dcci_pkg::FRAC_W) + dcci_pkg::SUM_W'(prod2_q);
  assign mac_d = dcci_pkg::MAC_W'(sum >>> dcci_pkg::FRAC_W);

  always_comb begin
    if (sum[dcci_pkg::SUM_W-1]) begin
      byte_d = '0;
    end else if (|sum[dcci_pkg::SUM_W-2:dcci_pkg::FRAC_W+4+dcci_pkg::BYTE_W]) begin
      byte_d = '1;
    end else begin
      byte_d = sum[dcci_pkg::FRAC_W+4+dcci_pkg::BYTE_W-1:dcci_pkg::FRAC_W+4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      src1_q <= src_i;
      sat1_q <= sat_d;
      w1_q   <= blend_i;
    end
    if (en_i.en2) begin
      src2_q  <= src1_q;
      prod2_q <= prod_d;
    end
    if (en_i.en3) begin
      mac3_q  <= mac_d;
      byte3_q <= byte_d;
    end
  end

  assign mac_o  = mac3_q;
  assign byte_o = byte3_q;

endmodule

`default_nettype wire

[src/depth_cue_color_interpolator_core.sv]
// A request accepted into stage one moves on to stage two and then to stage three, whose
// registers drive the outputs. Throughput: one request per cycle while any stage is free;
// a new request is taken while results wait downstream, until every stage is full.
// Stall: each of the three stages holds when the one after it is full and stalled.
// Reset: rst_ni (asynchronous, active low) empties the pipeline and clears the far colour.
// The configuration port is always ready.
`default_nettype none

module depth_cue_color_interpolator_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration write channel.
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [dcci_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [dcci_pkg::FAR_W-1:0]            cfg_data_i,
  // Input request channel.
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  command_i,
  input  wire logic signed [dcci_pkg::CHAN_W-1:0]    chan_one_in_i,
  input  wire logic signed [dcci_pkg::CHAN_W-1:0]    chan_two_in_i,
  input  wire logic signed [dcci_pkg::CHAN_W-1:0]    chan_three_in_i,
  input  wire logic [31:0]                           color_in_i,
  input  wire logic signed [dcci_pkg::CHAN_W-1:0]    blend_factor_i,
  // Result channel.
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [dcci_pkg::MAC_W-1:0]          mac_red_o,
  output logic signed [dcci_pkg::MAC_W-1:0]          mac_green_o,
  output logic signed [dcci_pkg::MAC_W-1:0]          mac_blue_o,
  output logic [31:0]                                color_out_o
);

  // Far colour registers, written by the user only while the pipeline is idle; not enforced.
  logic signed [dcci_pkg::FAR_W-1:0] far_red_q, far_green_q, far_blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      far_red_q   <= '0;
      far_green_q <= '0;
      far_blue_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dcci_pkg::REG_FAR_RED:   far_red_q   <= cfg_data_i;
        dcci_pkg::REG_FAR_GREEN: far_green_q <= cfg_data_i;
        dcci_pkg::REG_FAR_BLUE:  far_blue_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Stage control. A stage loads whenever it is empty or its contents move on,
  // so the pipeline keeps filling while only the output waits, until every stage is full.
  logic v1_q, v2_q, v3_q;
  dcci_pkg::stage_en_t en;

  assign en.en3 = !v3_q || out_ready_i;
  assign en.en2 = !v2_q || en.en3;
  assign en.en1 = !v1_q || en.en2;
  assign in_ready_o = en.en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en.en1) v1_q <= in_valid_i;
      if (en.en2) v2_q <= v1_q;
      if (en.en3) v3_q <= v2_q;
    end
  end

  // Command and code byte travel beside the channel lanes.
  logic       cue1_q, cue2_q, cue3_q;
  logic [7:0] code1_q, code2_q, code3_q;

  always_ff @(posedge clk_i) begin
    if (en.en1) begin
      cue1_q  <= (command_i == dcci_pkg::CMD_DEPTH_CUE);
      code1_q <= color_in_i[31:24];
    end
    if (en.en2) begin
      cue2_q  <= cue1_q;
      code2_q <= code1_q;
    end
    if (en.en3) begin
      cue3_q  <= cue2_q;
      code3_q <= code2_q;
    end
  end

  // Source selection: for depth cue each colour byte is scaled by sixteen,
  // which still fits a signed 16-bit source.
  logic signed [dcci_pkg::CHAN_W-1:0] src_r, src_g, src_b;
  logic                               cue_in;

  assign cue_in = (command_i == dcci_pkg::CMD_DEPTH_CUE);
  assign src_r  = cue_in ? {4'b0, color_in_i[7:0],   4'b0} : chan_one_in_i;
  assign src_g  = cue_in ? {4'b0, color_in_i[15:8],  4'b0} : chan_two_in_i;
  assign src_b  = cue_in ? {4'b0, color_in_i[23:16], 4'b0} : chan_three_in_i;

  logic [7:0] byte_r, byte_g, byte_b;

  dcci_lane u_lane_red (
    .clk_i   (clk_i),
    .en_i    (en),
    .src_i   (src_r),
    .far_i   (far_red_q),
    .blend_i (blend_factor_i),
    .mac_o   (mac_red_o),
    .byte_o  (byte_r)
  );

  dcci_lane u_lane_green (
    .clk_i   (clk_i),
    .en_i    (en),
    .src_i   (src_g),
    .far_i   (far_green_q),
    .blend_i (blend_factor_i),
    .mac_o   (mac_green_o),
    .byte_o  (byte_g)
  );

  dcci_lane u_lane_blue (
    .clk_i   (clk_i),
    .en_i    (en),
    .src_i   (src_b),
    .far_i   (far_blue_q),
    .blend_i (blend_factor_i),
    .mac_o   (mac_blue_o),
    .byte_o  (byte_b)
  );

  // Interpolate requests report a zero packed colour.
  assign color_out_o = cue3_q ? {code3_q, byte_b, byte_g, byte_r} : 32'd0;
  assign out_valid_o = v3_q;

`ifndef ASSERT_OFF
  // The number of requests in flight follows accepts and deliveries exactly.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones({v1_q, v2_q, v3_q}) ==
             $past($countones({v1_q, v2_q, v3_q})) + $past(in_valid_i && in_ready_o)
             - $past(out_valid_o && out_ready_i))
    else $error("pipeline occupancy does not match the handshakes");

  // Input back-pressure only appears when every stage is full and the output is stalled.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && !out_ready_i))
    else $error("input stalled while the pipeline has room");

  // A stalled output keeps the request behind it in place.
  a_hold_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !out_ready_i && v2_q) |=> v2_q)
    else $error("request behind a stalled output was lost");
`endif

endmodule

`default_nettype wire

[test/depth_cue_color_interpolator_core_test.sv]
`default_nettype none

// Self-checking bench for the depth-cue colour interpolator.
// Requests come from a queue that the main sequence fills. A clocked driver offers them to the
// block with random idle bursts. A clocked monitor takes results with random stalls and
// compares each one with the prediction made when the request was offered. The far colour
// changes only between phases, once the pipeline has drained.
module depth_cue_color_interpolator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Long receiver hold-off, in cycles, so that the pipeline fills and the input stalls.
  localparam int LONG_HOLD = 150;
  // Cycles without any accepted request before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  // Random requests in each of the random phases.
  localparam int PHASE_REQUESTS = 123;
  localparam int RANDOM_PHASES = 10;
  // Saturation bounds of the clipped colour difference.
  localparam int DIFF_MAX = 32767;
  localparam int DIFF_MIN = -32768;
  // Unlisted register index: a write to it must leave the far colour alone.
  localparam logic [dcci_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [dcci_pkg::FAR_W-1:0] FAR_EXTREMES [4] = '{
    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff
  };

  typedef struct {
    logic                               command;
    logic signed [dcci_pkg::CHAN_W-1:0] chan_one;
    logic signed [dcci_pkg::CHAN_W-1:0] chan_two;
    logic signed [dcci_pkg::CHAN_W-1:0] chan_three;
    logic [31:0]                        colour;
    logic signed [dcci_pkg::CHAN_W-1:0] blend;
  } request_t;

  typedef struct {
    logic signed [dcci_pkg::MAC_W-1:0] mac_red;
    logic signed [dcci_pkg::MAC_W-1:0] mac_green;
    logic signed [dcci_pkg::MAC_W-1:0] mac_blue;
    logic [31:0]                       colour;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [dcci_pkg::CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [dcci_pkg::FAR_W-1:0]         cfg_data_i = '0;

  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic                               command_i = dcci_pkg::CMD_INTERPOLATE;
  logic signed [dcci_pkg::CHAN_W-1:0] chan_one_in_i = '0;
  logic signed [dcci_pkg::CHAN_W-1:0] chan_two_in_i = '0;
  logic signed [dcci_pkg::CHAN_W-1:0] chan_three_in_i = '0;
  logic [31:0]                        color_in_i = '0;
  logic signed [dcci_pkg::CHAN_W-1:0] blend_factor_i = '0;

  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic signed [dcci_pkg::MAC_W-1:0]  mac_red_o;
  logic signed [dcci_pkg::MAC_W-1:0]  mac_green_o;
  logic signed [dcci_pkg::MAC_W-1:0]  mac_blue_o;
  logic [31:0]                        color_out_o;

  // Bench copy of the far colour registers, reset to zero like the block.
  logic signed [dcci_pkg::FAR_W-1:0] far_red_q = '0;
  logic signed [dcci_pkg::FAR_W-1:0] far_green_q = '0;
  logic signed [dcci_pkg::FAR_W-1:0] far_blue_q = '0;

  request_t queued_requests [$];
  pixel_t   predicted_pixels [$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  send_gap = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  // When set, neither side idles; the last phase runs this way.
  bit  calm = 1'b0;

  always #2 clk_i = ~clk_i;

  depth_cue_color_interpolator_core uut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .chan_one_in_i,
    .chan_two_in_i,
    .chan_three_in_i,
    .color_in_i,
    .blend_factor_i,
    .out_valid_o,
    .out_ready_i,
    .mac_red_o,
    .mac_green_o,
    .mac_blue_o,
    .color_out_o
  );

  // One channel pulled toward its far component. The difference is formed at 12 fractional
  // bits, wrapped to 44 bits, brought back to integer and clipped to 16 bits before it is
  // weighted; the weighted sum wraps at 44 bits as well.
  function automatic logic signed [dcci_pkg::MAC_W-1:0] pull_toward_far(
    input logic signed [31:0]                 src,
    input logic signed [dcci_pkg::FAR_W-1:0]  far_c,
    input logic signed [dcci_pkg::CHAN_W-1:0] weight
  );
    longint            wide;
    logic signed [43:0] acc;
    logic signed [31:0] diff;
    logic signed [31:0] clipped;
    wide = (longint'(far_c) - longint'(src)) <<< dcci_pkg::FRAC_W;
    acc = wide[43:0];
    diff = 32'(acc >>> dcci_pkg::FRAC_W);
    if (diff > DIFF_MAX) begin
      clipped = DIFF_MAX;
    end else if (diff < DIFF_MIN) begin
      clipped = DIFF_MIN;
    end else begin
      clipped = diff;
    end
    wide = (longint'(src) <<< dcci_pkg::FRAC_W) + longint'(weight) * longint'(clipped);
    acc = wide[43:0];
    return 32'(acc >>> dcci_pkg::FRAC_W);
  endfunction

  // The depth-cue colour keeps four fractional bits in the accumulator; the byte is the
  // accumulator shifted down by four and held within 0..255.
  function automatic logic [dcci_pkg::BYTE_W-1:0] clamp_to_byte(
    input logic signed [dcci_pkg::MAC_W-1:0] mac
  );
    logic signed [dcci_pkg::MAC_W-1:0] level;
    level = mac >>> 4;
    if (level < 0) return 8'h00;
    if (level > 255) return 8'hff;
    return level[dcci_pkg::BYTE_W-1:0];
  endfunction

  function automatic pixel_t interpolate_pixel(input request_t rq);
    pixel_t            px;
    logic signed [31:0] src [3];
    if (rq.command == dcci_pkg::CMD_DEPTH_CUE) begin
      // Each colour byte enters with four fractional bits; the channel fields do not count.
      src[0] = {20'd0, rq.colour[7:0], 4'd0};
      src[1] = {20'd0, rq.colour[15:8], 4'd0};
      src[2] = {20'd0, rq.colour[23:16], 4'd0};
    end else begin
      src[0] = rq.chan_one;
      src[1] = rq.chan_two;
      src[2] = rq.chan_three;
    end
    px.mac_red = pull_toward_far(src[0], far_red_q, rq.blend);
    px.mac_green = pull_toward_far(src[1], far_green_q, rq.blend);
    px.mac_blue = pull_toward_far(src[2], far_blue_q, rq.blend);
    // Interpolation reports no packed colour; depth cue repacks and keeps the code byte.
    if (rq.command == dcci_pkg::CMD_DEPTH_CUE) begin
      px.colour = {rq.colour[31:24], clamp_to_byte(px.mac_blue),
                   clamp_to_byte(px.mac_green), clamp_to_byte(px.mac_red)};
    end else begin
      px.colour = 32'd0;
    end
    return px;
  endfunction

  // Channel values lean towards the extremes and towards small magnitudes.
  function automatic logic signed [dcci_pkg::CHAN_W-1:0] random_chan();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return 16'($urandom_range(0, 8192)) - 16'sd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t rq;
    rq.command = $urandom_range(0, 1) ? dcci_pkg::CMD_DEPTH_CUE : dcci_pkg::CMD_INTERPOLATE;
    rq.chan_one = random_chan();
    rq.chan_two = random_chan();
    rq.chan_three = random_chan();
    rq.colour = $urandom;
    case ($urandom_range(0, 4))
      0: rq.blend = 16'sh1000;
      1: rq.blend = 16'($urandom_range(0, 4096));
      2: begin
        case ($urandom_range(0, 2))
          0: rq.blend = 16'sh7fff;
          1: rq.blend = 16'sh8000;
          default: rq.blend = 16'sh0000;
        endcase
      end
      default: rq.blend = 16'($urandom);
    endcase
    return rq;
  endfunction

  task automatic offer(input logic cmd, input logic [15:0] c1, input logic [15:0] c2,
                       input logic [15:0] c3, input logic [31:0] col, input logic [15:0] blend);
    request_t rq;
    rq.command = cmd;
    rq.chan_one = c1;
    rq.chan_two = c2;
    rq.chan_three = c3;
    rq.colour = col;
    rq.blend = blend;
    queued_requests.push_back(rq);
  endtask

  // Wait until every queued request has been sent and every predicted result has arrived.
  task automatic drain();
    while (queued_requests.size() != 0 || predicted_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Writes the three far colour registers back to back, valid held high throughout, and
  // optionally a write to the unlisted index, which the block must ignore.
  task automatic load_far_colour(input logic [dcci_pkg::FAR_W-1:0] r,
                                 input logic [dcci_pkg::FAR_W-1:0] g,
                                 input logic [dcci_pkg::FAR_W-1:0] b, input bit poke_spare);
    logic [dcci_pkg::CFG_IDX_W-1:0] idx [$];
    logic [dcci_pkg::FAR_W-1:0]     val [$];
    idx = '{dcci_pkg::REG_FAR_RED, dcci_pkg::REG_FAR_GREEN, dcci_pkg::REG_FAR_BLUE};
    val = '{r, g, b};
    if (poke_spare) begin
      idx.push_back(REG_SPARE);
      val.push_back($urandom);
    end
    @(posedge clk_i);
    for (int k = 0; k < idx.size(); k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[k])
        dcci_pkg::REG_FAR_RED: far_red_q = val[k];
        dcci_pkg::REG_FAR_GREEN: far_green_q = val[k];
        dcci_pkg::REG_FAR_BLUE: far_blue_q = val[k];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Request driver. A new request is placed on the bus only when the previous one has been
  // taken, and its result is predicted at that moment, so the prediction is queued well
  // before the result can appear at the output.
  always @(posedge clk_i) begin : request_driver
    request_t rq;
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          rq = queued_requests.pop_front();
          in_valid_i <= 1'b1;
          command_i <= rq.command;
          chan_one_in_i <= rq.chan_one;
          chan_two_in_i <= rq.chan_two;
          chan_three_in_i <= rq.chan_three;
          color_in_i <= rq.colour;
          blend_factor_i <= rq.blend;
          predicted_pixels.push_back(interpolate_pixel(rq));
          // Now and then an idle burst follows this request.
          if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor. It checks every accepted result against the oldest prediction and then
  // decides whether to stall. After the 400th and 900th result it holds off for a long
  // stretch, so that the three stages fill while the driver keeps offering requests.
  always @(posedge clk_i) begin : result_monitor
    pixel_t want;
    bit     took;
    if (rst_ni) begin
      took = out_valid_o && out_ready_i;
      if (took) begin
        results_seen++;
        if (predicted_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result mac %0d %0d %0d colour %h", $time,
                   mac_red_o, mac_green_o, mac_blue_o, color_out_o);
        end else begin
          want = predicted_pixels.pop_front();
          if (mac_red_o !== want.mac_red || mac_green_o !== want.mac_green ||
              mac_blue_o !== want.mac_blue || color_out_o !== want.colour) begin
            mismatches++;
            $display("%0t: expected mac %0d %0d %0d colour %h, got mac %0d %0d %0d colour %h",
                     $time, want.mac_red, want.mac_green, want.mac_blue, want.colour,
                     mac_red_o, mac_green_o, mac_blue_o, color_out_o);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (took && (results_seen == 400 || results_seen == 900)) begin
        hold_left <= LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold_left <= $urandom_range(1, 8) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: the run is declared hung when nothing at all is accepted for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, nothing accepted for %0d cycles", $time, quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [dcci_pkg::FAR_W-1:0] r;
    logic [dcci_pkg::FAR_W-1:0] g;
    logic [dcci_pkg::FAR_W-1:0] b;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Far colour still at its reset value of zero: channel extremes and both commands.
    // The packed colour rides along under interpolation and must not show in the result.
    offer(dcci_pkg::CMD_INTERPOLATE, 16'h7fff, 16'h8000, 16'h0000, 32'h1234_5678, 16'h1000);
    offer(dcci_pkg::CMD_INTERPOLATE, 16'h8000, 16'h7fff, 16'h0001, 32'h0000_0000, 16'h8000);
    offer(dcci_pkg::CMD_INTERPOLATE, 16'h0000, 16'hffff, 16'h7fff, 32'hffff_ffff, 16'h7fff);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h1111, 16'h2222, 16'h3333, 32'hffff_ffff, 16'h0000);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 16'h1000);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h7fff, 16'h8000, 16'h0000, 32'ha512_3456, 16'h0800);
    drain();

    // Extreme far colour: the scaled difference wraps at 44 bits and then saturates.
    load_far_colour(32'h7fff_ffff, 32'h8000_0000, 32'h0000_7fff, 1'b0);
    offer(dcci_pkg::CMD_INTERPOLATE, 16'h8000, 16'h7fff, 16'h0000, 32'h0000_0000, 16'h7fff);
    offer(dcci_pkg::CMD_INTERPOLATE, 16'h7fff, 16'h8000, 16'hffff, 32'hffff_ffff, 16'h8000);
    offer(dcci_pkg::CMD_INTERPOLATE, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 16'h1000);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h0000, 16'h0000, 16'h0000, 32'h80ff_00ff, 16'h7fff);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'hffff, 16'hffff, 16'hffff, 32'h7f00_ff00, 16'h8000);
    drain();

    // The opposite extremes, with a stray write to the unlisted index among them.
    load_far_colour(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
    offer(dcci_pkg::CMD_INTERPOLATE, 16'h7fff, 16'h8000, 16'h7fff, 32'h5a5a_5a5a, 16'h7fff);
    offer(dcci_pkg::CMD_INTERPOLATE, 16'h8000, 16'h7fff, 16'h8000, 32'h0000_0000, 16'h8000);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h0000, 16'h0000, 16'h0000, 32'hffff_ffff, 16'h1000);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 16'hf000);
    drain();

    // A modest far colour, so that depth cue lands both inside and outside the byte range.
    load_far_colour(32'h0000_0ff0, 32'h0000_0000, 32'h0000_0800, 1'b0);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h0000, 16'h0000, 16'h0000, 32'h00ff_00ff, 16'h0000);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h0000, 16'h0000, 16'h0000, 32'h3c80_ff10, 16'h0400);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h0000, 16'h0000, 16'h0000, 32'hc300_ff80, 16'h1000);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h0000, 16'h0000, 16'h0000, 32'h0180_40c0, 16'hf000);
    offer(dcci_pkg::CMD_DEPTH_CUE, 16'h0000, 16'h0000, 16'h0000, 32'hff40_8020, 16'h2000);
    offer(dcci_pkg::CMD_INTERPOLATE, 16'h0ff0, 16'h0000, 16'h0800, 32'h0000_0000, 16'h1000);
    drain();

    // Random phases, each under a fresh far colour. The last one runs without idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 5)
        1: begin
          r = $urandom_range(0, 4095);
          g = $urandom_range(0, 4095);
          b = $urandom_range(0, 4095);
        end
        2: begin
          // Around the saturation edge of the clipped difference.
          r = $urandom_range(0, 80000) - 40000;
          g = $urandom_range(0, 80000) - 40000;
          b = $urandom_range(0, 80000) - 40000;
        end
        3: begin
          r = FAR_EXTREMES[$urandom_range(0, 3)];
          g = FAR_EXTREMES[$urandom_range(0, 3)];
          b = FAR_EXTREMES[$urandom_range(0, 3)];
        end
        default: begin
          r = $urandom;
          g = $urandom;
          b = $urandom;
        end
      endcase
      load_far_colour(r, g, b, p == 5);
      calm = (p == RANDOM_PHASES - 1);
      repeat (PHASE_REQUESTS) queued_requests.push_back(random_request());
      drain();
    end

    // A few more edges, so that any stray result would still be caught.
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
